// ===== hw/rtl/fsa_pkg.sv =====
// Shared types, character constants and microcode ROM for the format string formatter.
// Used by fsa_datapath and format_string_to_ascii_stream; depends on nothing else.
`default_nettype none

package fsa_pkg;

  typedef struct packed {
    logic [7:0]         fmt_byte;
    logic signed [31:0] arg_value;
  } in_t;

  typedef struct packed {
    logic [7:0] out_char;
    logic       last_of_run;
  } out_t;

  localparam logic [7:0] CH_NUL   = 8'h00;
  localparam logic [7:0] CH_LF    = 8'h0a;
  localparam logic [7:0] CH_CR    = 8'h0d;
  localparam logic [7:0] CH_PCT   = 8'h25;
  localparam logic [7:0] CH_MINUS = 8'h2d;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_LOW_A = 8'h61;
  localparam logic [7:0] CH_D     = 8'h64;
  localparam logic [7:0] CH_P     = 8'h70;
  localparam logic [7:0] CH_X     = 8'h78;

  // floor(x / 10) == (x * DEC_RECIP) >> DEC_SHIFT for every 32-bit x
  localparam logic [31:0] DEC_RECIP = 32'hcccc_cccd;
  localparam int          DEC_SHIFT = 35;

  localparam int STACK_DEPTH = 11;

  localparam int PC_W = 5;

  localparam logic [3:0] OP_WAIT     = 4'd0;
  localparam logic [3:0] OP_JUMP     = 4'd1;
  localparam logic [3:0] OP_EMIT     = 4'd2;
  localparam logic [3:0] OP_CLRPEND  = 4'd3;
  localparam logic [3:0] OP_SETPEND  = 4'd4;
  localparam logic [3:0] OP_PREP_DEC = 4'd5;
  localparam logic [3:0] OP_PREP_HEX = 4'd6;
  localparam logic [3:0] OP_MUL      = 4'd7;
  localparam logic [3:0] OP_DIGIT    = 4'd8;
  localparam logic [3:0] OP_PUSHNEG  = 4'd9;

  localparam logic [3:0] COND_NEVER  = 4'd0;
  localparam logic [3:0] COND_ALWAYS = 4'd1;
  localparam logic [3:0] COND_NUL    = 4'd2;
  localparam logic [3:0] COND_PEND   = 4'd3;
  localparam logic [3:0] COND_PCT    = 4'd4;
  localparam logic [3:0] COND_NL     = 4'd5;
  localparam logic [3:0] COND_DEC    = 4'd6;
  localparam logic [3:0] COND_HEX    = 4'd7;
  localparam logic [3:0] COND_MAGNZ  = 4'd8;
  localparam logic [3:0] COND_MORE   = 4'd9;

  localparam logic [1:0] SRC_CH    = 2'd0;
  localparam logic [1:0] SRC_PCT   = 2'd1;
  localparam logic [1:0] SRC_CR    = 2'd2;
  localparam logic [1:0] SRC_STACK = 2'd3;

  localparam logic [1:0] LAST_NO     = 2'd0;
  localparam logic [1:0] LAST_YES    = 2'd1;
  localparam logic [1:0] LAST_NOT_NL = 2'd2;
  localparam logic [1:0] LAST_SP_ONE = 2'd3;

  typedef struct packed {
    logic [3:0]      op;
    logic [3:0]      cond;
    logic [1:0]      src;
    logic [1:0]      last;
    logic [PC_W-1:0] target;
  } ucode_t;

  typedef struct packed {
    logic load_arg;
    logic prep_dec;
    logic prep_hex;
    logic mul;
    logic digit;
    logic push_neg;
    logic pop;
  } dp_ctrl_t;

  typedef struct packed {
    logic       mag_nz;
    logic       sp_one;
    logic [7:0] top_char;
  } dp_stat_t;

  function automatic ucode_t uw(logic [3:0] op, logic [3:0] cond, logic [1:0] src,
                                logic [1:0] last, logic [PC_W-1:0] target);
    ucode_t w;
    w.op     = op;
    w.cond   = cond;
    w.src    = src;
    w.last   = last;
    w.target = target;
    return w;
  endfunction

  function automatic logic [7:0] hex_char(logic [3:0] d);
    logic [7:0] c;
    if (d < 4'd10) begin
      c = CH_ZERO + {4'd0, d};
    end else begin
      c = CH_LOW_A + {4'd0, d} - 8'd10;
    end
    return c;
  endfunction

  function automatic ucode_t ucode(logic [PC_W-1:0] pc);
    ucode_t w;
    unique case (pc)
      5'd0:    w = uw(OP_WAIT,     COND_NEVER,  SRC_CH,    LAST_NO,     5'd0);
      5'd1:    w = uw(OP_JUMP,     COND_NUL,    SRC_CH,    LAST_NO,     5'd24);
      5'd2:    w = uw(OP_JUMP,     COND_PEND,   SRC_CH,    LAST_NO,     5'd6);
      5'd3:    w = uw(OP_JUMP,     COND_PCT,    SRC_CH,    LAST_NO,     5'd25);
      5'd4:    w = uw(OP_EMIT,     COND_NL,     SRC_CH,    LAST_NOT_NL, 5'd23);
      5'd5:    w = uw(OP_JUMP,     COND_ALWAYS, SRC_CH,    LAST_NO,     5'd0);
      5'd6:    w = uw(OP_CLRPEND,  COND_DEC,    SRC_CH,    LAST_NO,     5'd12);
      5'd7:    w = uw(OP_JUMP,     COND_HEX,    SRC_CH,    LAST_NO,     5'd17);
      5'd8:    w = uw(OP_JUMP,     COND_PCT,    SRC_CH,    LAST_NO,     5'd22);
      5'd9:    w = uw(OP_EMIT,     COND_NEVER,  SRC_PCT,   LAST_NO,     5'd0);
      5'd10:   w = uw(OP_EMIT,     COND_NL,     SRC_CH,    LAST_NOT_NL, 5'd23);
      5'd11:   w = uw(OP_JUMP,     COND_ALWAYS, SRC_CH,    LAST_NO,     5'd0);
      5'd12:   w = uw(OP_PREP_DEC, COND_NEVER,  SRC_CH,    LAST_NO,     5'd0);
      5'd13:   w = uw(OP_MUL,      COND_NEVER,  SRC_CH,    LAST_NO,     5'd0);
      5'd14:   w = uw(OP_DIGIT,    COND_NEVER,  SRC_CH,    LAST_NO,     5'd0);
      5'd15:   w = uw(OP_JUMP,     COND_MAGNZ,  SRC_CH,    LAST_NO,     5'd13);
      5'd16:   w = uw(OP_PUSHNEG,  COND_ALWAYS, SRC_CH,    LAST_NO,     5'd20);
      5'd17:   w = uw(OP_PREP_HEX, COND_NEVER,  SRC_CH,    LAST_NO,     5'd0);
      5'd18:   w = uw(OP_DIGIT,    COND_NEVER,  SRC_CH,    LAST_NO,     5'd0);
      5'd19:   w = uw(OP_JUMP,     COND_MAGNZ,  SRC_CH,    LAST_NO,     5'd18);
      5'd20:   w = uw(OP_EMIT,     COND_MORE,   SRC_STACK, LAST_SP_ONE, 5'd20);
      5'd21:   w = uw(OP_JUMP,     COND_ALWAYS, SRC_CH,    LAST_NO,     5'd0);
      5'd22:   w = uw(OP_EMIT,     COND_ALWAYS, SRC_PCT,   LAST_YES,    5'd0);
      5'd23:   w = uw(OP_EMIT,     COND_ALWAYS, SRC_CR,    LAST_YES,    5'd0);
      5'd24:   w = uw(OP_CLRPEND,  COND_ALWAYS, SRC_CH,    LAST_NO,     5'd0);
      5'd25:   w = uw(OP_SETPEND,  COND_ALWAYS, SRC_CH,    LAST_NO,     5'd0);
      default: w = uw(OP_JUMP,     COND_ALWAYS, SRC_CH,    LAST_NO,     5'd0);
    endcase
    return w;
  endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/fsa_datapath.sv =====
// Number conversion datapath: magnitude register, reciprocal multiplier and digit stack.
// Driven by the sequencer in format_string_to_ascii_stream; uses fsa_pkg.
`default_nettype none

module fsa_datapath (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic [31:0]         arg_in,
  input  wire fsa_pkg::dp_ctrl_t   ctrl,
  output fsa_pkg::dp_stat_t        stat
);

  logic [31:0] arg;
  logic [31:0] mag;
  logic [63:0] prod;
  logic        neg;
  logic        hexm;
  logic [3:0]  sp;
  logic [7:0]  stack [0:fsa_pkg::STACK_DEPTH-1];

  logic [28:0] quo;
  logic [31:0] quo10;
  logic [31:0] rem;
  logic [3:0]  dig;
  logic [31:0] mag_next;

  always_comb begin
    quo   = prod[63:fsa_pkg::DEC_SHIFT];
    quo10 = {quo, 3'b000} + {2'b00, quo, 1'b0};
    rem   = mag - quo10;
    if (hexm) begin
      dig      = mag[3:0];
      mag_next = {4'd0, mag[31:4]};
    end else begin
      dig      = rem[3:0];
      mag_next = {3'd0, quo};
    end
  end

  always_ff @(posedge clk) begin
    if (ctrl.load_arg) begin
      arg <= arg_in;
    end
    if (ctrl.prep_dec) begin
      neg  <= arg[31];
      mag  <= arg[31] ? 32'd0 - arg : arg;
      hexm <= 1'b0;
    end else if (ctrl.prep_hex) begin
      neg  <= 1'b0;
      mag  <= arg;
      hexm <= 1'b1;
    end else if (ctrl.digit) begin
      mag <= mag_next;
    end
    if (ctrl.mul) begin
      prod <= 64'(mag) * 64'(fsa_pkg::DEC_RECIP);
    end
    if (ctrl.digit) begin
      stack[sp] <= fsa_pkg::hex_char(dig);
    end else if (ctrl.push_neg && neg) begin
      stack[sp] <= fsa_pkg::CH_MINUS;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sp <= 4'd0;
    end else if (ctrl.prep_dec || ctrl.prep_hex) begin
      sp <= 4'd0;
    end else if (ctrl.digit || (ctrl.push_neg && neg)) begin
      sp <= sp + 4'd1;
    end else if (ctrl.pop) begin
      sp <= sp - 4'd1;
    end
  end

  assign stat.mag_nz   = (mag != 32'd0);
  assign stat.sp_one   = (sp == 4'd1);
  assign stat.top_char = stack[sp - 4'd1];

endmodule

`default_nettype wire

// ===== hw/rtl/format_string_to_ascii_stream.sv =====
// Flow: a plain byte passes the NUL, pending and percent tests before it is emitted;
// hex loops over digit and test per digit, decimal over multiply, digit and test, before output.
// Throughput: one character per cycle out while out_ready is held; a new request is taken
// only once the microcode is back in its wait step after the last one. Set by the microcode
// loop and the single output register.
// Reset: synchronous; clears the step counter, percent pending and output valid.
// Top level: microcode sequencer; uses fsa_pkg and fsa_datapath.
`default_nettype none

module format_string_to_ascii_stream (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         in_valid,
  output logic              in_ready,
  input  wire fsa_pkg::in_t in_data,
  output logic              out_valid,
  input  wire logic         out_ready,
  output fsa_pkg::out_t     out_data
);

  logic [fsa_pkg::PC_W-1:0] pc;
  logic [fsa_pkg::PC_W-1:0] pc_next;
  fsa_pkg::ucode_t          cw;
  logic [7:0]               ch;
  logic                     pending;
  logic                     done;
  logic                     cond_true;
  logic                     emit_fire;
  logic [7:0]               emit_char;
  logic                     emit_last;
  fsa_pkg::dp_ctrl_t        dp_ctrl;
  fsa_pkg::dp_stat_t        dp_stat;

  assign cw       = fsa_pkg::ucode(pc);
  assign in_ready = (cw.op == fsa_pkg::OP_WAIT);

  always_comb begin
    unique case (cw.op)
      fsa_pkg::OP_WAIT: done = in_valid;
      fsa_pkg::OP_EMIT: done = !out_valid || out_ready;
      default:          done = 1'b1;
    endcase
    unique case (cw.cond)
      fsa_pkg::COND_ALWAYS: cond_true = 1'b1;
      fsa_pkg::COND_NUL:    cond_true = (ch == fsa_pkg::CH_NUL);
      fsa_pkg::COND_PEND:   cond_true = pending;
      fsa_pkg::COND_PCT:    cond_true = (ch == fsa_pkg::CH_PCT);
      fsa_pkg::COND_NL:     cond_true = (ch == fsa_pkg::CH_LF);
      fsa_pkg::COND_DEC:    cond_true = (ch == fsa_pkg::CH_D);
      fsa_pkg::COND_HEX:    cond_true = (ch == fsa_pkg::CH_X) || (ch == fsa_pkg::CH_P);
      fsa_pkg::COND_MAGNZ:  cond_true = dp_stat.mag_nz;
      fsa_pkg::COND_MORE:   cond_true = !dp_stat.sp_one;
      default:              cond_true = 1'b0;
    endcase
    if (!done) begin
      pc_next = pc;
    end else if (cond_true) begin
      pc_next = cw.target;
    end else begin
      pc_next = pc + 5'd1;
    end
  end

  always_comb begin
    unique case (cw.src)
      fsa_pkg::SRC_CH:    emit_char = ch;
      fsa_pkg::SRC_PCT:   emit_char = fsa_pkg::CH_PCT;
      fsa_pkg::SRC_CR:    emit_char = fsa_pkg::CH_CR;
      default:            emit_char = dp_stat.top_char;
    endcase
    unique case (cw.last)
      fsa_pkg::LAST_YES:    emit_last = 1'b1;
      fsa_pkg::LAST_NOT_NL: emit_last = (ch != fsa_pkg::CH_LF);
      fsa_pkg::LAST_SP_ONE: emit_last = dp_stat.sp_one;
      default:              emit_last = 1'b0;
    endcase
  end

  assign emit_fire = (cw.op == fsa_pkg::OP_EMIT) && done;

  assign dp_ctrl.load_arg = (cw.op == fsa_pkg::OP_WAIT) && in_valid;
  assign dp_ctrl.prep_dec = (cw.op == fsa_pkg::OP_PREP_DEC);
  assign dp_ctrl.prep_hex = (cw.op == fsa_pkg::OP_PREP_HEX);
  assign dp_ctrl.mul      = (cw.op == fsa_pkg::OP_MUL);
  assign dp_ctrl.digit    = (cw.op == fsa_pkg::OP_DIGIT);
  assign dp_ctrl.push_neg = (cw.op == fsa_pkg::OP_PUSHNEG);
  assign dp_ctrl.pop      = emit_fire && (cw.src == fsa_pkg::SRC_STACK);

  fsa_datapath u_datapath (
    .clk    (clk),
    .rst    (rst),
    .arg_in (in_data.arg_value),
    .ctrl   (dp_ctrl),
    .stat   (dp_stat)
  );

  always_ff @(posedge clk) begin
    if (dp_ctrl.load_arg) begin
      ch <= in_data.fmt_byte;
    end
    if (emit_fire) begin
      out_data.out_char    <= emit_char;
      out_data.last_of_run <= emit_last;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pc        <= '0;
      pending   <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      pc <= pc_next;
      if (cw.op == fsa_pkg::OP_CLRPEND) begin
        pending <= 1'b0;
      end else if (cw.op == fsa_pkg::OP_SETPEND) begin
        pending <= 1'b1;
      end
      if (emit_fire) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

`default_nettype wire

// ===== verif/testbench.sv =====
// Self-checking testbench for format_string_to_ascii_stream: a queue-fed driver, a monitor
// and an in-line predictor of the character stream with random idling on both sides.
// Depends on fsa_pkg for the request and character payload types.
module testbench;

  localparam logic [7:0] CH_S = 8'h73;
  localparam int LIMIT_CYCLES = 600000;

  typedef struct {
    fsa_pkg::in_t data;
    bit           drain;
  } fmt_req_t;

  logic          clk = 1'b0;
  logic          rst = 1'b1;
  logic          in_valid = 1'b0;
  logic          in_ready;
  fsa_pkg::in_t  in_data = '0;
  logic          out_valid;
  logic          out_ready = 1'b0;
  fsa_pkg::out_t out_data;

  fmt_req_t      req_q[$];
  fmt_req_t      next_req;
  fsa_pkg::out_t expected_chars[$];
  logic [7:0]    run_chars[$];
  bit            pct_pending;

  int  total_reqs;
  int  reqs_taken;
  int  chars_seen;
  int  conversions;
  int  mismatches;
  int  gap_left;
  int  stall_left;
  int  long_left;
  bit  long_done;
  bit  calm_tail;
  fsa_pkg::out_t want;

  format_string_to_ascii_stream u_top (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  task automatic report_mismatch(input string msg);
    mismatches++;
    $display("MISMATCH @%0t: %s", $time, msg);
  endtask

  function automatic void add_char(input logic [7:0] c);
    run_chars.push_back(c);
    if (c == fsa_pkg::CH_LF) begin
      run_chars.push_back(fsa_pkg::CH_CR);
    end
  endfunction

  function automatic void add_number(input logic [31:0] word, input bit as_decimal);
    logic [31:0] mag;
    logic [31:0] base;
    logic [31:0] d;
    logic [7:0]  digs[$];
    mag = word;
    base = as_decimal ? 32'd10 : 32'd16;
    if (as_decimal && word[31]) begin
      add_char(fsa_pkg::CH_MINUS);
      mag = 32'd0 - word;
    end
    do begin
      d = mag % base;
      digs.push_front((d < 32'd10) ? fsa_pkg::CH_ZERO + d[7:0] :
                                     fsa_pkg::CH_LOW_A + d[7:0] - 8'd10);
      mag = mag / base;
    end while (mag != 32'd0);
    foreach (digs[i]) begin
      add_char(digs[i]);
    end
  endfunction

  function automatic void predict_chars(input fsa_pkg::in_t req);
    fsa_pkg::out_t item;
    run_chars.delete();
    if (req.fmt_byte == fsa_pkg::CH_NUL) begin
      pct_pending = 1'b0;
    end else if (!pct_pending) begin
      if (req.fmt_byte == fsa_pkg::CH_PCT) begin
        pct_pending = 1'b1;
      end else begin
        add_char(req.fmt_byte);
      end
    end else begin
      pct_pending = 1'b0;
      conversions++;
      if (req.fmt_byte == fsa_pkg::CH_D) begin
        add_number(req.arg_value, 1'b1);
      end else if (req.fmt_byte == fsa_pkg::CH_X || req.fmt_byte == fsa_pkg::CH_P) begin
        add_number(req.arg_value, 1'b0);
      end else if (req.fmt_byte == fsa_pkg::CH_PCT) begin
        add_char(fsa_pkg::CH_PCT);
      end else begin
        add_char(fsa_pkg::CH_PCT);
        add_char(req.fmt_byte);
      end
    end
    foreach (run_chars[i]) begin
      item.out_char = run_chars[i];
      item.last_of_run = (i == run_chars.size() - 1);
      expected_chars.push_back(item);
    end
  endfunction

  function automatic void queue_req(input logic [7:0] b, input logic [31:0] a,
                                    input bit drain = 1'b0);
    fmt_req_t r;
    r.data.fmt_byte = b;
    r.data.arg_value = a;
    r.drain = drain;
    req_q.push_back(r);
  endfunction

  function automatic logic [31:0] rand_arg();
    logic [31:0] a;
    case ($urandom_range(0, 4))
      0: a = $urandom_range(0, 20);
      1: a = 32'd0 - $urandom_range(1, 20);
      2: begin
        case ($urandom_range(0, 3))
          0: a = 32'h0000_0000;
          1: a = 32'h8000_0000;
          2: a = 32'h7fff_ffff;
          default: a = 32'hffff_ffff;
        endcase
      end
      default: a = $urandom;
    endcase
    return a;
  endfunction

  function automatic logic [7:0] rand_conv();
    logic [7:0] c;
    case ($urandom_range(0, 5))
      0, 1: c = fsa_pkg::CH_D;
      2: c = fsa_pkg::CH_X;
      3: c = fsa_pkg::CH_P;
      4: c = fsa_pkg::CH_PCT;
      default: c = 8'($urandom_range(1, 255));
    endcase
    return c;
  endfunction

  // sender: hold the request until taken, then offer the next or idle
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      in_data <= '0;
      gap_left = 0;
    end else begin
      if (in_valid && in_ready) begin
        predict_chars(in_data);
        reqs_taken++;
      end
      calm_tail = (req_q.size() < 50);
      if (!(in_valid && !in_ready)) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (req_q.size() == 0) begin
          in_valid <= 1'b0;
        end else if (req_q[0].drain && expected_chars.size() != 0) begin
          in_valid <= 1'b0;
        end else if (!calm_tail && long_left == 0 && ((reqs_taken / 40) % 3) != 2 &&
                     $urandom_range(0, 7) == 0) begin
          gap_left = $urandom_range(0, 16);
          in_valid <= 1'b0;
        end else begin
          next_req = req_q.pop_front();
          in_valid <= 1'b1;
          in_data <= next_req.data;
        end
      end
    end
  end

  // receiver: check each character, then choose ready for the next cycle
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
      stall_left = 0;
      long_left = 0;
    end else begin
      if (out_valid && out_ready) begin
        chars_seen++;
        if (expected_chars.size() == 0) begin
          report_mismatch($sformatf("unexpected char %h last %b",
                                    out_data.out_char, out_data.last_of_run));
        end else begin
          want = expected_chars.pop_front();
          if (out_data.out_char !== want.out_char) begin
            report_mismatch($sformatf("char %h, want %h", out_data.out_char, want.out_char));
          end
          if (out_data.last_of_run !== want.last_of_run) begin
            report_mismatch($sformatf("last_of_run %b, want %b on char %h",
                                      out_data.last_of_run, want.last_of_run,
                                      want.out_char));
          end
        end
      end
      if (long_left > 0) begin
        long_left--;
        out_ready <= 1'b0;
      end else if (!long_done && chars_seen >= 400) begin
        long_done = 1'b1;
        long_left = 299;
        out_ready <= 1'b0;
      end else if (stall_left > 0) begin
        stall_left--;
        out_ready <= 1'b0;
      end else if (!calm_tail && ((chars_seen / 100) % 3) != 2 &&
                   $urandom_range(0, 7) == 0) begin
        stall_left = $urandom_range(0, 16);
        out_ready <= 1'b0;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  initial begin
    int rand_reqs;
    int drain_at;
    logic [7:0] b;

    queue_req(8'h41, 32'h0);
    queue_req(fsa_pkg::CH_LF, $urandom);
    queue_req(fsa_pkg::CH_PCT, $urandom);
    queue_req(fsa_pkg::CH_D, 32'h0000_0000);
    queue_req(fsa_pkg::CH_PCT, $urandom);
    queue_req(fsa_pkg::CH_D, 32'h8000_0000);
    queue_req(fsa_pkg::CH_PCT, $urandom);
    queue_req(fsa_pkg::CH_D, 32'h7fff_ffff);
    queue_req(fsa_pkg::CH_PCT, $urandom);
    queue_req(fsa_pkg::CH_X, 32'h0000_0000);
    queue_req(fsa_pkg::CH_PCT, $urandom);
    queue_req(fsa_pkg::CH_X, 32'hffff_ffff);
    queue_req(fsa_pkg::CH_PCT, $urandom);
    queue_req(fsa_pkg::CH_P, 32'h8000_0000);
    queue_req(fsa_pkg::CH_PCT, $urandom);
    queue_req(fsa_pkg::CH_PCT, $urandom);
    queue_req(fsa_pkg::CH_PCT, $urandom);
    queue_req(CH_S, $urandom);
    queue_req(fsa_pkg::CH_PCT, $urandom);
    queue_req(fsa_pkg::CH_LF, $urandom);
    queue_req(fsa_pkg::CH_PCT, $urandom);
    queue_req(fsa_pkg::CH_NUL, $urandom);
    queue_req(fsa_pkg::CH_NUL, $urandom);
    queue_req(8'hff, 32'hffff_ffff);

    rand_reqs = 0;
    drain_at = 0;
    while (rand_reqs < 430) begin
      b = 8'($urandom_range(0, 9));
      case (b)
        0, 1, 2, 3, 4: begin
          queue_req(fsa_pkg::CH_PCT, $urandom, rand_reqs >= drain_at);
          if (rand_reqs >= drain_at) begin
            drain_at += 150;
          end
          queue_req(rand_conv(), rand_arg());
          rand_reqs += 2;
        end
        5, 6: begin
          queue_req(8'($urandom_range(1, 255)), $urandom);
          rand_reqs++;
        end
        7: begin
          queue_req(fsa_pkg::CH_NUL, $urandom);
          rand_reqs++;
        end
        8: begin
          queue_req(fsa_pkg::CH_PCT, $urandom);
          queue_req(fsa_pkg::CH_NUL, rand_arg());
          rand_reqs += 2;
        end
        default: begin
          queue_req(8'($urandom_range(0, 255)), rand_arg());
          rand_reqs++;
        end
      endcase
    end
    total_reqs = req_q.size();

    repeat (4) @(posedge clk);
    rst <= 1'b0;

    while (reqs_taken < total_reqs) @(posedge clk);
    while (expected_chars.size() != 0) @(posedge clk);
    repeat (100) @(posedge clk);

    $display("Run covered %0d format bytes, %0d percent conversions, %0d characters checked",
             reqs_taken, conversions, chars_seen);
    $display("with decimal and hex extremes, NUL termination and idling on both sides.");
    if (mismatches == 0 && expected_chars.size() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  initial begin
    #(LIMIT_CYCLES * 12);
    $display("Timeout after %0d cycles", LIMIT_CYCLES);
    $display("Mismatches found");
    $finish;
  end

endmodule
